>>> rtl/battery_charge_from_voltage_defines.svh
// assertion macros for the battery charge block
// used by the modules that check their own control logic; needs clk_i and rst_ni in scope
`ifndef BATTERY_CHARGE_FROM_VOLTAGE_DEFINES_SVH
`define BATTERY_CHARGE_FROM_VOLTAGE_DEFINES_SVH

`ifndef SYNTHESIS
`define BCV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bcv assertion failed");
`define BCV_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("bcv forbidden condition seen");
`else
`define BCV_ASSERT(lbl, prop)
`define BCV_ASSERT_NEVER(lbl, expr)
`endif

`endif

>>> rtl/bcv_pkg.sv
// shared types, widths and curve tables of the battery charge block
// no dependencies; tables are built at elaboration from the breakpoint list
package bcv_pkg;

  localparam int unsigned CURVE_POINTS   = 21;
  localparam int unsigned ADC_FULL_SCALE = 4095;
  localparam int unsigned STORED_POINTS  = 21;
  localparam int unsigned USED_POINTS    =
    (CURVE_POINTS > STORED_POINTS) ? STORED_POINTS :
    ((CURVE_POINTS < 2) ? 2 : CURVE_POINTS);
  localparam int unsigned NUM_SEGS = USED_POINTS - 1;

  localparam int unsigned ADC_W   = 12;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned THR_W   = 7;
  localparam int unsigned CODE_W  = $clog2(ADC_FULL_SCALE + 1);
  localparam int unsigned CMP_W   = (CODE_W > ADC_W) ? CODE_W : ADC_W;
  localparam int unsigned SEG_W   = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
  localparam int unsigned PROD_W  = CODE_W + PCT_W;
  localparam int unsigned NUM_W   = CODE_W + 8;
  localparam int unsigned RECIP_W = NUM_W;

  localparam int unsigned PCT_FULL      = 100;
  localparam int unsigned THR_RESET     = 20;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MULT,
    S_RECIP,
    S_FIX
  } state_e;

  typedef struct packed {
    logic load;
    logic search;
    logic mult;
    logic recip;
    logic fix;
  } cmd_t;

  typedef logic [USED_POINTS-1:0][CODE_W-1:0] code_tab_t;
  typedef logic [NUM_SEGS-1:0][CODE_W-1:0]    seg_code_tab_t;
  typedef logic [NUM_SEGS-1:0][PCT_W-1:0]     seg_pct_tab_t;
  typedef logic [NUM_SEGS-1:0][RECIP_W-1:0]   seg_recip_tab_t;

  // breakpoints in hundredths of a volt
  function automatic int unsigned curve_cv(int unsigned k);
    int unsigned cv;
    unique case (k)
      0:  cv = 327;
      1:  cv = 361;
      2:  cv = 369;
      3:  cv = 371;
      4:  cv = 373;
      5:  cv = 375;
      6:  cv = 377;
      7:  cv = 379;
      8:  cv = 380;
      9:  cv = 382;
      10: cv = 384;
      11: cv = 385;
      12: cv = 387;
      13: cv = 391;
      14: cv = 395;
      15: cv = 398;
      16: cv = 402;
      17: cv = 408;
      18: cv = 411;
      19: cv = 415;
      default: cv = 420;
    endcase
    return cv;
  endfunction

  // adc code of a breakpoint, rounded half up
  function automatic int unsigned point_code(int unsigned k);
    return (2 * curve_cv(k) * ADC_FULL_SCALE + 420) / 840;
  endfunction

  function automatic int unsigned point_pct(int unsigned k);
    return (200 * k + NUM_SEGS) / (2 * NUM_SEGS);
  endfunction

  // floor(2^NUM_W / den) by restoring long division
  function automatic longint unsigned recip_of(longint unsigned den);
    longint unsigned rem;
    longint unsigned quo;
    rem = 0;
    quo = 0;
    for (int i = NUM_W; i >= 0; i--) begin
      rem = (rem << 1) | ((i == NUM_W) ? 64'd1 : 64'd0);
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  function automatic code_tab_t build_codes();
    code_tab_t t;
    for (int unsigned k = 0; k < USED_POINTS; k++) begin
      t[k] = CODE_W'(point_code(k));
    end
    return t;
  endfunction

  function automatic seg_code_tab_t build_widths();
    seg_code_tab_t t;
    for (int unsigned k = 0; k < NUM_SEGS; k++) begin
      t[k] = CODE_W'(point_code(k + 1) - point_code(k));
    end
    return t;
  endfunction

  function automatic seg_pct_tab_t build_plo();
    seg_pct_tab_t t;
    for (int unsigned k = 0; k < NUM_SEGS; k++) begin
      t[k] = PCT_W'(point_pct(k));
    end
    return t;
  endfunction

  function automatic seg_pct_tab_t build_dp();
    seg_pct_tab_t t;
    for (int unsigned k = 0; k < NUM_SEGS; k++) begin
      t[k] = PCT_W'(point_pct(k + 1) - point_pct(k));
    end
    return t;
  endfunction

  // floor(2^NUM_W / (2*d)) per segment, zero for a flat segment
  function automatic seg_recip_tab_t build_recip();
    seg_recip_tab_t t;
    longint unsigned w;
    for (int unsigned k = 0; k < NUM_SEGS; k++) begin
      w = longint'(point_code(k + 1)) - longint'(point_code(k));
      t[k] = (w == 0) ? '0 : RECIP_W'(recip_of(2 * w));
    end
    return t;
  endfunction

  localparam code_tab_t      CODES     = build_codes();
  localparam seg_code_tab_t  SEG_D     = build_widths();
  localparam seg_pct_tab_t   SEG_PLO   = build_plo();
  localparam seg_pct_tab_t   SEG_DP    = build_dp();
  localparam seg_recip_tab_t SEG_RECIP = build_recip();
  localparam logic [PCT_W-1:0] LAST_PCT = PCT_W'(point_pct(USED_POINTS - 1));

endpackage

>>> rtl/battery_charge_from_voltage.sv
// battery state of charge from one adc sample, piecewise linear over a 21-point curve
// the result strobe follows the correction step; no new sample is taken while busy
// the sequencer runs its steps in order: search, multiply, reciprocal multiply, correction
// results are strobed for one cycle and cannot be stalled by the receiver
// asynchronous active-low reset: sequencer idle, threshold back to 20 percent
// depends on bcv_pkg, bcv_ctrl and bcv_datapath
module battery_charge_from_voltage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command side
  input  logic                       start,
  output logic                       busy,
  input  logic [bcv_pkg::ADC_W-1:0]  adc_sample_i,
  // result side
  output logic                       result_valid_o,
  output logic [bcv_pkg::PCT_W-1:0]  charge_percent_o,
  output logic                       battery_low_o,
  // threshold write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bcv_pkg::THR_W-1:0]  cfg_data_i
);
  import bcv_pkg::*;

  cmd_t cmd;

  // the threshold register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  // sequencer: one step per cycle, strobe follows the correction step
  bcv_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (result_valid_o),
    .cmd_o  (cmd)
  );

  // datapath: results stay in their output registers until the next sample finishes
  bcv_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .adc_sample_i     (adc_sample_i),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .charge_percent_o (charge_percent_o),
    .battery_low_o    (battery_low_o)
  );

endmodule

>>> rtl/bcv_ctrl.sv
// sequencer of the battery charge block: steps one sample through the datapath
// depends on bcv_pkg and battery_charge_from_voltage_defines.svh
`include "battery_charge_from_voltage_defines.svh"

module bcv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  output bcv_pkg::cmd_t cmd_o
);
  import bcv_pkg::*;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start) state_d = S_SEARCH;
      S_SEARCH: state_d = S_MULT;
      S_MULT:   state_d = S_RECIP;
      S_RECIP:  state_d = S_FIX;
      S_FIX:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:   cmd_o.load   = start;
      S_SEARCH: cmd_o.search = 1'b1;
      S_MULT:   cmd_o.mult   = 1'b1;
      S_RECIP:  cmd_o.recip  = 1'b1;
      S_FIX:    cmd_o.fix    = 1'b1;
      default:  cmd_o        = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_FIX);
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

  `BCV_ASSERT(a_accept_makes_busy, (start && !busy) |=> busy)
  `BCV_ASSERT(a_strobe_after_fix, (state_q == S_FIX) |=> done_o)
  `BCV_ASSERT(a_strobe_only_idle, done_o |-> !busy)
  `BCV_ASSERT_NEVER(a_cmd_overlap, !$onehot0(cmd_o))

endmodule

>>> rtl/bcv_datapath.sv
// datapath of the battery charge block: segment search, interpolation, threshold
// depends on bcv_pkg; steps are driven by bcv_ctrl commands
module bcv_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bcv_pkg::cmd_t               cmd_i,
  input  logic [bcv_pkg::ADC_W-1:0]   adc_sample_i,
  input  logic                        cfg_we_i,
  input  logic [bcv_pkg::THR_W-1:0]   cfg_data_i,
  output logic [bcv_pkg::PCT_W-1:0]   charge_percent_o,
  output logic                        battery_low_o
);
  import bcv_pkg::*;

  logic [ADC_W-1:0]   x_q;
  logic [THR_W-1:0]   thr_q;
  logic [SEG_W-1:0]   seg_q, seg_d;
  logic               direct_q, direct_d;
  logic [PCT_W-1:0]   direct_pct_q, direct_pct_d;
  logic [CODE_W-1:0]  diff_q, diff_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [PCT_W-1:0]   q0_q, q0_d;
  logic [PCT_W-1:0]   pct_q, pct_d;
  logic               low_q;

  logic [CMP_W-1:0]     x_ext;
  logic [2*NUM_W-1:0]   est;
  logic [CODE_W:0]      two_d;
  logic [NUM_W-1:0]     rem;
  logic [PCT_W:0]       q_fix;
  logic [PCT_W:0]       sum;

  // segment search: largest breakpoint at or below the sample
  always_comb begin
    x_ext        = CMP_W'(x_q);
    seg_d        = '0;
    direct_d     = 1'b0;
    direct_pct_d = '0;
    for (int unsigned k = 0; k < NUM_SEGS; k++) begin
      if (x_ext >= CMP_W'(CODES[k])) seg_d = SEG_W'(k);
    end
    if (x_ext >= CMP_W'(ADC_FULL_SCALE)) begin
      direct_d     = 1'b1;
      direct_pct_d = PCT_W'(PCT_FULL);
    end else if (x_ext < CMP_W'(CODES[0])) begin
      direct_d     = 1'b1;
      direct_pct_d = '0;
    end else if (x_ext >= CMP_W'(CODES[USED_POINTS-1])) begin
      direct_d     = 1'b1;
      direct_pct_d = LAST_PCT;
    end
    diff_d = CODE_W'(x_ext - CMP_W'(CODES[seg_d]));
  end

  // numerator 2*(x-lo)*dp + d
  assign num_d = NUM_W'({PROD_W'(diff_q * SEG_DP[seg_q]), 1'b0}) + NUM_W'(SEG_D[seg_q]);

  // quotient estimate by reciprocal, low by at most one
  assign est  = num_q * SEG_RECIP[seg_q];
  assign q0_d = est[NUM_W +: PCT_W];

  // correction and clamp
  always_comb begin
    two_d = {SEG_D[seg_q], 1'b0};
    rem   = num_q - NUM_W'(q0_q * two_d);
    q_fix = {1'b0, q0_q} + ((rem >= NUM_W'(two_d)) ? (PCT_W+1)'(1) : '0);
    if (SEG_D[seg_q] == '0) q_fix = '0;
    sum = {1'b0, SEG_PLO[seg_q]} + q_fix;
    if (direct_q) begin
      pct_d = direct_pct_q;
    end else if (sum > (PCT_W+1)'(PCT_FULL)) begin
      pct_d = PCT_W'(PCT_FULL);
    end else begin
      pct_d = sum[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(THR_RESET);
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) x_q <= adc_sample_i;
    if (cmd_i.search) begin
      seg_q        <= seg_d;
      direct_q     <= direct_d;
      direct_pct_q <= direct_pct_d;
      diff_q       <= diff_d;
    end
    if (cmd_i.mult)  num_q <= num_d;
    if (cmd_i.recip) q0_q  <= q0_d;
    if (cmd_i.fix) begin
      pct_q <= pct_d;
      low_q <= (pct_d < thr_q);
    end
  end

  assign charge_percent_o = pct_q;
  assign battery_low_o    = low_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for battery_charge_from_voltage: directed samples, then random ones
// predicts percent and low flag from its own copy of the voltage curve; needs bcv_pkg and the rtl
module testbench;

  import bcv_pkg::*;

  // one result transaction as it leaves the block
  typedef struct packed {
    logic [PCT_W-1:0] pct;
    logic             low;
  } soc_result_t;

  // one row of the directed stimulus; the typed rows carry their result
  typedef struct packed {
    logic [ADC_W-1:0] sample;
    logic             typed;
    logic [PCT_W-1:0] pct;
    logic             low;
  } stim_row_t;

  localparam int unsigned KNEES      = 21;
  localparam int unsigned PHASES     = 7;
  localparam int unsigned PHASE_LEN  = 250;
  localparam int unsigned SETTLE_CYC = 20;
  localparam int unsigned DIR_ROWS   = 22;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [ADC_W-1:0] adc_sample_i;
  logic             result_valid_o;
  logic [PCT_W-1:0] charge_percent_o;
  logic             battery_low_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [THR_W-1:0] cfg_data_i;

  // curve knees in hundredths of a volt, 3.27 v up to full scale
  int unsigned knee_cv [KNEES] = '{
    327, 361, 369, 371, 373, 375, 377, 379, 380, 382, 384,
    385, 387, 391, 395, 398, 402, 408, 411, 415, 420
  };

  // threshold as the block holds it, tracked at each accepted write
  logic [THR_W-1:0] low_thr;
  soc_result_t      charge_q [$];
  soc_result_t      due;
  int unsigned      mismatches;

  // sample rows: extremes, alternating bit patterns, knees and their neighbors
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{12'd0,    1'b1, 7'd0,   1'b1},  // bottom of adc range
    '{12'd4095, 1'b1, 7'd100, 1'b0},  // full scale
    '{12'd3187, 1'b1, 7'd0,   1'b1},  // just under the first knee
    '{12'd2730, 1'b1, 7'd0,   1'b1},  // 0xaaa, below the curve
    '{12'd1365, 1'b1, 7'd0,   1'b1},  // 0x555, below the curve
    '{12'd2048, 1'b1, 7'd0,   1'b1},
    '{12'd3188, 1'b0, 7'd0,   1'b0},  // first knee itself
    '{12'd3189, 1'b0, 7'd0,   1'b0},
    '{12'd3354, 1'b0, 7'd0,   1'b0},  // inside the long first segment
    '{12'd3519, 1'b0, 7'd0,   1'b0},
    '{12'd3520, 1'b0, 7'd0,   1'b0},
    '{12'd3521, 1'b0, 7'd0,   1'b0},
    '{12'd3600, 1'b0, 7'd0,   1'b0},
    '{12'd3695, 1'b0, 7'd0,   1'b0},
    '{12'd3700, 1'b0, 7'd0,   1'b0},
    '{12'd3705, 1'b0, 7'd0,   1'b0},
    '{12'd3850, 1'b0, 7'd0,   1'b0},
    '{12'd4000, 1'b0, 7'd0,   1'b0},
    '{12'd4045, 1'b0, 7'd0,   1'b0},
    '{12'd4046, 1'b0, 7'd0,   1'b0},
    '{12'd4047, 1'b0, 7'd0,   1'b0},
    '{12'd4094, 1'b0, 7'd0,   1'b0}   // last code below full scale
  };

  battery_charge_from_voltage uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .adc_sample_i     (adc_sample_i),
    .result_valid_o   (result_valid_o),
    .charge_percent_o (charge_percent_o),
    .battery_low_o    (battery_low_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // adc code of knee k, voltage scaled so that 4.2 v is full scale, halves rounded up
  function automatic int unsigned knee_code(int unsigned k);
    return (2 * knee_cv[k] * ADC_FULL_SCALE + 420) / 840;
  endfunction

  // percent at knee k, evenly spread over the curve
  function automatic int unsigned knee_pct(int unsigned k);
    return (200 * k + (KNEES - 1)) / (2 * (KNEES - 1));
  endfunction

  // charge estimate: find the segment, then interpolate with rounding half up
  function automatic soc_result_t predict_charge(logic [ADC_W-1:0] sample);
    soc_result_t res;
    int unsigned x;
    int unsigned seg;
    int unsigned lo;
    int unsigned hi;
    int unsigned plo;
    int unsigned phi;
    int unsigned pct;
    x = sample;
    seg = KNEES - 1;
    if (x >= ADC_FULL_SCALE) begin
      pct = 100;
    end else if (x < knee_code(0)) begin
      pct = 0;
    end else begin
      while (seg > 0 && x < knee_code(seg)) seg--;
      if (seg >= KNEES - 1) begin
        // only when the curve ends below full scale
        pct = knee_pct(KNEES - 1);
      end else begin
        lo  = knee_code(seg);
        hi  = knee_code(seg + 1);
        plo = knee_pct(seg);
        phi = knee_pct(seg + 1);
        if (hi <= lo) begin
          pct = plo;  // flat segment
        end else begin
          pct = plo + (2 * (x - lo) * (phi - plo) + (hi - lo)) / (2 * (hi - lo));
        end
        if (pct > 100) pct = 100;
      end
    end
    res.pct = PCT_W'(pct);
    res.low = (pct < low_thr);
    return res;
  endfunction

  // weighted towards the curve, with knee neighbors, the region below, full scale and any code
  function automatic logic [ADC_W-1:0] pick_sample();
    int unsigned r;
    int          c;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return ADC_W'($urandom_range(knee_code(0), ADC_FULL_SCALE - 1));
    end else if (r < 75) begin
      c = int'(knee_code($urandom_range(0, KNEES - 1))) + int'($urandom_range(0, 2)) - 1;
      if (c > ADC_FULL_SCALE) c = ADC_FULL_SCALE;
      return ADC_W'(c);
    end else if (r < 85) begin
      return ADC_W'($urandom_range(0, knee_code(0) - 1));
    end else if (r < 90) begin
      return ADC_W'(ADC_FULL_SCALE);
    end
    return ADC_W'($urandom);
  endfunction

  // present one sample from the falling edge and hold it until the block takes it
  task automatic issue_sample(input logic [ADC_W-1:0] sample, input logic typed,
                              input soc_result_t typed_res);
    @(negedge clk_i);
    start        = 1'b1;
    adc_sample_i = sample;
    do @(posedge clk_i); while (busy);
    // transaction accepted at this edge
    if (typed) charge_q.push_back(typed_res);
    else charge_q.push_back(predict_charge(sample));
  endtask

  // sender goes quiet; the sample bus carries noise the block must ignore
  task automatic idle_gap(input int unsigned cycles);
    @(negedge clk_i);
    start        = 1'b0;
    adc_sample_i = ADC_W'($urandom);
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // threshold update, only once the block has drained every pending result
  task automatic write_threshold(input logic [THR_W-1:0] thr);
    @(negedge clk_i);
    start = 1'b0;
    while (charge_q.size() != 0 || busy) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    low_thr = thr;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = THR_W'($urandom);
  endtask

  // every strobed result is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (charge_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual pct=%0d low=%0b",
                 $time, charge_percent_o, battery_low_o);
        mismatches++;
      end else begin
        due = charge_q.pop_front();
        if (charge_percent_o !== due.pct) begin
          $display("%0t: charge_percent mismatch: expected %0d, actual %0d",
                   $time, due.pct, charge_percent_o);
          mismatches++;
        end
        if (battery_low_o !== due.low) begin
          $display("%0t: battery_low mismatch: expected %0b, actual %0b",
                   $time, due.low, battery_low_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [THR_W-1:0] phase_thr [PHASES];
    int unsigned      gap_odds;
    soc_result_t      row_res;

    mismatches   = 0;
    low_thr      = THR_W'(THR_RESET);
    rst_ni       = 1'b0;
    start        = 1'b0;
    adc_sample_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part runs with the threshold left at its reset value
    for (int i = 0; i < DIR_ROWS; i++) begin
      row_res.pct = dir_rows[i].pct;
      row_res.low = dir_rows[i].low;
      issue_sample(dir_rows[i].sample, dir_rows[i].typed, row_res);
      if (i % 4 == 3) idle_gap($urandom_range(1, 14));
    end

    // threshold settings: both ends, above the percent range, and a few in between
    phase_thr = '{7'd0, 7'd100, 7'd127, 7'd101, THR_W'($urandom_range(2, 99)), 7'd1,
                  THR_W'($urandom_range(2, 99))};

    for (int p = 0; p < PHASES; p++) begin
      write_threshold(phase_thr[p]);
      gap_odds = 0;
      for (int i = 0; i < PHASE_LEN; i++) begin
        // idling density changes every few dozen transactions, sometimes none at all
        if (i % 48 == 0) gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        issue_sample(pick_sample(), 1'b0, row_res);
        // last phase runs back to back
        if (p < PHASES - 1 && $urandom_range(0, 99) < gap_odds) begin
          idle_gap($urandom_range(1, 14));
        end
      end
    end

    @(negedge clk_i);
    start = 1'b0;
    while (charge_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bcv_pkg.sv
rtl/bcv_ctrl.sv
rtl/bcv_datapath.sv
rtl/battery_charge_from_voltage.sv
tb/testbench.sv
